/* hdl/per_source_rate_ban_table_macros.svh */
// Assertion macros used by the rate ban table sequencer (psrb_ctl).
`ifndef PER_SOURCE_RATE_BAN_TABLE_MACROS_SVH
`define PER_SOURCE_RATE_BAN_TABLE_MACROS_SVH

// Same-cycle implication under the active-low reset.
`define PSRB_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psrb assertion failed");

// Next-cycle implication under the active-low reset.
`define PSRB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psrb assertion failed");

`endif

/* hdl/psrb_pkg.sv */
// Types, codes and helper functions of the rate ban table.
`default_nettype none
package psrb_pkg;

    localparam int TIE_W = 9;

    localparam logic [1:0] CMD_QUERY    = 2'd0;
    localparam logic [1:0] CMD_RESPONSE = 2'd1;
    localparam logic [1:0] CMD_CHECK    = 2'd2;

    localparam logic [1:0] REG_WINDOW = 2'd0;
    localparam logic [1:0] REG_BLOCK  = 2'd1;
    localparam logic [1:0] REG_QRATE  = 2'd2;
    localparam logic [1:0] REG_RLIMIT = 2'd3;

    localparam logic [30:0] TALLY_MAX = 31'h7FFF_FFFF;
    localparam logic [31:0] LFSR_MASK = 32'h8020_0003;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic        addr_is_v6;
        logic [15:0] byte_count;
        logic [31:0] now_seconds;
    } item_t;

    typedef struct packed {
        logic allowed;
        logic newly_banned;
    } result_t;

    typedef struct packed {
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic        is_v6;
        logic [31:0] tally;
        logic [31:0] last_seen;
        logic [31:0] deadline;
    } entry_t;

    typedef struct packed {
        logic [11:0] window_seconds;
        logic [16:0] block_seconds;
        logic [30:0] query_limit;
        logic [30:0] response_byte_limit;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic [31:0]      dividend;
        logic [TIE_W-1:0] divisor;
    } rem_req_t;

    typedef struct packed {
        logic done;
        logic zero;
    } rem_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_RD,
        ST_EVAL,
        ST_MODW,
        ST_WREF,
        ST_UPD,
        ST_RESP
    } state_t;

    typedef enum logic [1:0] {
        PH_REFRESH,
        PH_CHARGE,
        PH_CHECK0,
        PH_CHECK1
    } phase_t;

    function automatic logic [31:0] add_time(input logic [31:0] t, input logic [31:0] d);
        logic [32:0] s;
        s = {1'b0, t} + {1'b0, d};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [31:0] lfsr_step(input logic [31:0] v);
        return v[0] ? ((v >> 1) ^ LFSR_MASK) : (v >> 1);
    endfunction

endpackage
`default_nettype wire

/* hdl/psrb_rem.sv */
// Bit-serial remainder unit: 32-bit dividend modulo a small divisor.
`default_nettype none
module psrb_rem (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire psrb_pkg::rem_req_t req,
    output psrb_pkg::rem_rsp_t      rsp
);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [4:0]                 cnt_reg, cnt_next;
    logic [psrb_pkg::TIE_W-1:0] rem_reg, rem_next;
    logic [psrb_pkg::TIE_W-1:0] div_reg, div_next;
    logic [31:0]                shf_reg, shf_next;
    logic [psrb_pkg::TIE_W:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        shf_next  = shf_reg;
        trial     = {rem_reg, shf_reg[31]};
        if (trial >= {1'b0, div_reg})
        begin
            trial = trial - {1'b0, div_reg};
        end
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            div_next  = req.divisor;
            shf_next  = req.dividend;
        end
        else if (busy_reg)
        begin
            rem_next = trial[psrb_pkg::TIE_W-1:0];
            shf_next = shf_reg << 1;
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        shf_reg <= shf_next;
    end

    assign rsp.done = done_reg;
    assign rsp.zero = (rem_reg == '0);

endmodule
`default_nettype wire

/* hdl/psrb_ctl.sv */
// Sequencer, slot memory and result register of the rate ban table.
`default_nettype none
`include "per_source_rate_ban_table_macros.svh"
module psrb_ctl #(
    parameter int TABLE_SLOTS = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire psrb_pkg::cfg_t     cfg,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire psrb_pkg::item_t    item,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output psrb_pkg::result_t       result,
    output psrb_pkg::rem_req_t      rem_req,
    input  wire psrb_pkg::rem_rsp_t rem_rsp
);

    localparam int DEPTH = 2 * TABLE_SLOTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(TABLE_SLOTS);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SLOTS - 1);

    psrb_pkg::state_t  state_reg, state_next;
    psrb_pkg::phase_t  phase_reg, phase_next;
    psrb_pkg::item_t   item_reg, item_next;
    psrb_pkg::entry_t  cur_reg, cur_next;
    psrb_pkg::result_t res_reg, res_next;
    psrb_pkg::result_t out_reg;
    logic              out_valid_reg;
    logic              res_load;

    logic [IW-1:0]              idx_reg, idx_next;
    logic [IW-1:0]              lru_reg, lru_next;
    logic [31:0]                lru_ls_reg, lru_ls_next;
    logic [psrb_pkg::TIE_W-1:0] ties_reg, ties_next;
    logic [31:0]                lfsr_reg, lfsr_next;
    logic                       tbl_reg, tbl_next;
    logic                       hit_reg, hit_next;
    logic                       ban_reg, ban_next;
    logic [31:0]                nowpw_reg, nowpw_next;
    logic [31:0]                nowpb_reg, nowpb_next;
    logic [15:0]                amount_reg, amount_next;
    logic [31:0]                limit_reg, limit_next;

    psrb_pkg::entry_t mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    psrb_pkg::entry_t rd_q;
    logic             rd_valid_q;
    psrb_pkg::entry_t rd;
    logic [AW-1:0]    rd_addr;
    logic             we;
    logic [AW-1:0]    waddr;
    psrb_pkg::entry_t wdata;

    logic        match;
    logic        last;
    logic        is_tie;
    logic [31:0] step_val;
    logic [31:0] chk_limit;
    logic [31:0] old_tally;
    logic [31:0] old_dl;
    logic [31:0] sum;
    logic [31:0] sum_sat;
    logic [31:0] amt32;

    always_comb
    begin
        rd_addr = tbl_reg ? (AW'(TABLE_SLOTS) + AW'(idx_reg)) : AW'(idx_reg);
        rd      = rd_valid_q ? rd_q : '0;
        match   = (rd.addr_high == item_reg.addr_high) && (rd.addr_low == item_reg.addr_low)
                  && (rd.is_v6 == item_reg.addr_is_v6);
        last    = (idx_reg == LAST_IDX);
        is_tie  = (idx_reg != '0) && (rd.last_seen == lru_ls_reg);
        step_val = psrb_pkg::lfsr_step(lfsr_reg);
        chk_limit = (phase_reg == psrb_pkg::PH_CHECK0) ? {1'b0, cfg.query_limit}
                                                       : {1'b0, cfg.response_byte_limit};
        old_tally = hit_reg ? cur_reg.tally : 32'd0;
        old_dl    = hit_reg ? cur_reg.deadline : nowpw_reg;
        amt32     = {16'd0, amount_reg};
        sum       = old_tally + amt32;
        sum_sat   = sum[31] ? {1'b0, psrb_pkg::TALLY_MAX} : sum;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            psrb_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = psrb_pkg::ST_PREP;
                end
            end
            psrb_pkg::ST_PREP:
            begin
                if (item_reg.command inside {psrb_pkg::CMD_QUERY, psrb_pkg::CMD_RESPONSE,
                                             psrb_pkg::CMD_CHECK})
                begin
                    state_next = psrb_pkg::ST_RD;
                end
                else
                begin
                    state_next = psrb_pkg::ST_RESP;
                end
            end
            psrb_pkg::ST_RD:
            begin
                state_next = psrb_pkg::ST_EVAL;
            end
            psrb_pkg::ST_EVAL:
            begin
                case (phase_reg)
                    psrb_pkg::PH_CHECK0:
                    begin
                        state_next = psrb_pkg::ST_RD;
                    end
                    psrb_pkg::PH_CHECK1:
                    begin
                        state_next = (match || last) ? psrb_pkg::ST_RESP : psrb_pkg::ST_RD;
                    end
                    psrb_pkg::PH_REFRESH:
                    begin
                        state_next = match ? psrb_pkg::ST_WREF : psrb_pkg::ST_RD;
                    end
                    default:
                    begin
                        if (match)
                        begin
                            state_next = psrb_pkg::ST_UPD;
                        end
                        else if (is_tie && rd.last_seen >= lru_ls_reg)
                        begin
                            state_next = psrb_pkg::ST_MODW;
                        end
                        else
                        begin
                            state_next = last ? psrb_pkg::ST_UPD : psrb_pkg::ST_RD;
                        end
                    end
                endcase
            end
            psrb_pkg::ST_MODW:
            begin
                if (rem_rsp.done)
                begin
                    state_next = last ? psrb_pkg::ST_UPD : psrb_pkg::ST_RD;
                end
            end
            psrb_pkg::ST_WREF:
            begin
                state_next = psrb_pkg::ST_RD;
            end
            psrb_pkg::ST_UPD:
            begin
                state_next = psrb_pkg::ST_RESP;
            end
            psrb_pkg::ST_RESP:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    state_next = psrb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = psrb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        item_next   = item_reg;
        cur_next    = cur_reg;
        res_next    = res_reg;
        idx_next    = idx_reg;
        lru_next    = lru_reg;
        lru_ls_next = lru_ls_reg;
        ties_next   = ties_reg;
        lfsr_next   = lfsr_reg;
        tbl_next    = tbl_reg;
        hit_next    = hit_reg;
        ban_next    = ban_reg;
        nowpw_next  = nowpw_reg;
        nowpb_next  = nowpb_reg;
        amount_next = amount_reg;
        limit_next  = limit_reg;
        rem_req     = '0;
        we          = 1'b0;
        waddr       = rd_addr;
        wdata       = cur_reg;
        res_load    = 1'b0;
        case (state_reg)
            psrb_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_next = item;
                end
            end
            psrb_pkg::ST_PREP:
            begin
                nowpw_next = psrb_pkg::add_time(item_reg.now_seconds,
                                                {20'd0, cfg.window_seconds});
                nowpb_next = psrb_pkg::add_time(item_reg.now_seconds,
                                                {15'd0, cfg.block_seconds});
                idx_next   = '0;
                hit_next   = 1'b0;
                ban_next   = 1'b0;
                res_next   = '{allowed: 1'b1, newly_banned: 1'b0};
                if (item_reg.command == psrb_pkg::CMD_QUERY)
                begin
                    amount_next = 16'd1;
                    limit_next  = {1'b0, cfg.query_limit};
                    phase_next  = psrb_pkg::PH_REFRESH;
                    tbl_next    = 1'b1;
                end
                else if (item_reg.command == psrb_pkg::CMD_RESPONSE)
                begin
                    amount_next = item_reg.byte_count;
                    limit_next  = {1'b0, cfg.response_byte_limit};
                    phase_next  = psrb_pkg::PH_CHARGE;
                    tbl_next    = 1'b1;
                end
                else
                begin
                    phase_next = psrb_pkg::PH_CHECK0;
                    tbl_next   = 1'b0;
                end
            end
            psrb_pkg::ST_EVAL:
            begin
                case (phase_reg)
                    psrb_pkg::PH_CHECK0, psrb_pkg::PH_CHECK1:
                    begin
                        if (match)
                        begin
                            ban_next = ban_reg || ((rd.tally >= chk_limit)
                                       && (item_reg.now_seconds < rd.deadline));
                        end
                        if (match || last)
                        begin
                            idx_next = '0;
                            if (phase_reg == psrb_pkg::PH_CHECK0)
                            begin
                                phase_next = psrb_pkg::PH_CHECK1;
                                tbl_next   = 1'b1;
                            end
                            else
                            begin
                                res_next.allowed = !ban_next;
                            end
                        end
                        else
                        begin
                            idx_next = idx_reg + 1'b1;
                        end
                        if (phase_reg == psrb_pkg::PH_CHECK0 && !(match || last))
                        begin
                            phase_next = psrb_pkg::PH_CHECK0;
                        end
                    end
                    psrb_pkg::PH_REFRESH:
                    begin
                        if (match)
                        begin
                            cur_next = rd;
                        end
                        else if (last)
                        begin
                            phase_next = psrb_pkg::PH_CHARGE;
                            tbl_next   = 1'b0;
                            idx_next   = '0;
                        end
                        else
                        begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                        if (match)
                        begin
                            hit_next = 1'b1;
                            cur_next = rd;
                        end
                        else
                        begin
                            if (idx_reg == '0)
                            begin
                                lru_next    = '0;
                                lru_ls_next = rd.last_seen;
                                ties_next   = psrb_pkg::TIE_W'(1);
                            end
                            else if (rd.last_seen < lru_ls_reg)
                            begin
                                lru_next    = idx_reg;
                                lru_ls_next = rd.last_seen;
                                ties_next   = psrb_pkg::TIE_W'(1);
                            end
                            else if (is_tie)
                            begin
                                ties_next        = ties_reg + 1'b1;
                                lfsr_next        = step_val;
                                rem_req.start    = 1'b1;
                                rem_req.dividend = step_val;
                                rem_req.divisor  = ties_reg + 1'b1;
                            end
                            if (!is_tie && !last)
                            begin
                                idx_next = idx_reg + 1'b1;
                            end
                        end
                    end
                endcase
            end
            psrb_pkg::ST_MODW:
            begin
                if (rem_rsp.done)
                begin
                    if (rem_rsp.zero)
                    begin
                        lru_next = idx_reg;
                    end
                    if (!last)
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            psrb_pkg::ST_WREF:
            begin
                we              = 1'b1;
                wdata.last_seen = item_reg.now_seconds;
                phase_next      = psrb_pkg::PH_CHARGE;
                tbl_next        = 1'b0;
                idx_next        = '0;
            end
            psrb_pkg::ST_UPD:
            begin
                we = 1'b1;
                waddr = tbl_reg ? (AW'(TABLE_SLOTS) + AW'(hit_reg ? idx_reg : lru_reg))
                                : AW'(hit_reg ? idx_reg : lru_reg);
                wdata.addr_high = item_reg.addr_high;
                wdata.addr_low  = item_reg.addr_low;
                wdata.is_v6     = item_reg.addr_is_v6;
                wdata.last_seen = item_reg.now_seconds;
                wdata.tally     = sum_sat;
                wdata.deadline  = old_dl;
                res_next        = '{allowed: 1'b1, newly_banned: 1'b0};
                if (sum_sat >= limit_reg)
                begin
                    if (item_reg.now_seconds < old_dl)
                    begin
                        res_next.allowed = 1'b0;
                        if (old_tally < limit_reg)
                        begin
                            wdata.deadline        = nowpb_reg;
                            res_next.newly_banned = 1'b1;
                        end
                    end
                    else
                    begin
                        wdata.tally    = amt32;
                        wdata.deadline = nowpw_reg;
                        if (amt32 >= limit_reg)
                        begin
                            wdata.deadline = nowpb_reg;
                            res_next       = '{allowed: 1'b0, newly_banned: 1'b1};
                        end
                    end
                end
            end
            psrb_pkg::ST_RESP:
            begin
                res_load = !out_valid_reg || !result_stall;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= psrb_pkg::ST_IDLE;
            phase_reg     <= psrb_pkg::PH_CHECK0;
            lfsr_reg      <= 32'd1;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            lfsr_reg  <= lfsr_next;
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        cur_reg    <= cur_next;
        res_reg    <= res_next;
        idx_reg    <= idx_next;
        lru_reg    <= lru_next;
        lru_ls_reg <= lru_ls_next;
        ties_reg   <= ties_next;
        tbl_reg    <= tbl_next;
        hit_reg    <= hit_next;
        ban_reg    <= ban_next;
        nowpw_reg  <= nowpw_next;
        nowpb_reg  <= nowpb_next;
        amount_reg <= amount_next;
        limit_reg  <= limit_next;
        if (res_load)
        begin
            out_reg <= res_reg;
        end
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (state_reg == psrb_pkg::ST_RD)
        begin
            rd_q       <= mem[rd_addr];
            rd_valid_q <= valid_reg[rd_addr];
        end
    end

    assign item_stall   = (state_reg != psrb_pkg::ST_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    `PSRB_ASSERT_IMPL(a_rem_done_in_wait, rem_rsp.done, state_reg == psrb_pkg::ST_MODW)
    `PSRB_ASSERT_NEXT(a_read_then_eval, state_reg == psrb_pkg::ST_RD,
                      state_reg == psrb_pkg::ST_EVAL)
    `PSRB_ASSERT_IMPL(a_ban_blocks, out_valid_reg && out_reg.newly_banned, !out_reg.allowed)
    `PSRB_ASSERT_IMPL(a_write_states, we,
                      state_reg == psrb_pkg::ST_WREF || state_reg == psrb_pkg::ST_UPD)

endmodule
`default_nettype wire

/* hdl/per_source_rate_ban_table.sv */
// Top level of the per-source rate ban table: configuration registers and units.
//
// Channel  | Valid         | Stall         | Payload
// item     | item_valid    | item_stall    | item   (psrb_pkg::item_t)
// result   | result_valid  | result_stall  | result (psrb_pkg::result_t)
// config   | wr_en         | none          | wr_index, wr_data
//
// Each slot visited passes through a read state and an evaluate state; each tie on
// the oldest activity time also waits for the serial remainder unit.
// A query scans both tables.
// Reset clears the slot valid bits at once; no clearing pass is needed.
// A result waits in the output register while the next item is taken.
`default_nettype none
module per_source_rate_ban_table #(
    parameter int TABLE_SLOTS = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire logic [1:0]        wr_index,
    input  wire logic [30:0]       wr_data,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire psrb_pkg::item_t   item,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output psrb_pkg::result_t      result
);

    logic [11:0] window_reg;
    logic [16:0] block_reg;
    logic [19:0] qrate_reg;
    logic [30:0] rlimit_reg;
    logic [30:0] qlimit_reg;
    logic [31:0] qprod;

    psrb_pkg::cfg_t     cfg;
    psrb_pkg::rem_req_t rem_req;
    psrb_pkg::rem_rsp_t rem_rsp;

    assign qprod = {12'd0, qrate_reg} * {20'd0, window_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= 12'd5;
            block_reg  <= 17'd300;
            qrate_reg  <= 20'd5;
            rlimit_reg <= 31'd65536;
            qlimit_reg <= 31'd25;
        end
        else
        begin
            qlimit_reg <= qprod[31] ? psrb_pkg::TALLY_MAX : qprod[30:0];
            if (wr_en)
            begin
                case (wr_index)
                    psrb_pkg::REG_WINDOW: window_reg <= wr_data[11:0];
                    psrb_pkg::REG_BLOCK:  block_reg  <= wr_data[16:0];
                    psrb_pkg::REG_QRATE:  qrate_reg  <= wr_data[19:0];
                    psrb_pkg::REG_RLIMIT: rlimit_reg <= wr_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign cfg.window_seconds      = window_reg;
    assign cfg.block_seconds       = block_reg;
    assign cfg.query_limit         = qlimit_reg;
    assign cfg.response_byte_limit = rlimit_reg;

    psrb_ctl #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) u_ctl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .rem_req      (rem_req),
        .rem_rsp      (rem_rsp)
    );

    psrb_rem u_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rem_req),
        .rsp   (rem_rsp)
    );

endmodule
`default_nettype wire
